// File: rtl/keyframe_vector_interpolator_unit_assert.svh
// Assertion macros for the interpolator RTL.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_UNIT_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_UNIT_ASSERT_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define KVI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Whenever ante holds, cons must hold in the following cycle.
`define KVI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/kvi_pkg.sv
package kvi_pkg;

   // Table geometry and number formats.
   localparam int MAX_KEYS  = 64;
   localparam int KEY_AW    = 6;
   localparam int CNT_W     = 7;
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int FACT_W    = FRAC_W + 1;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int PROD_W    = DIFF_W + FACT_W + 1;
   localparam int DIV_CNT_W = $clog2(FRAC_W);

   // Item modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Vector component selects for the shared blend multiplier.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_K,
      ST_LD_K,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_FIN
   } kvi_state_type;

   // One stored key.
   typedef struct packed {
      logic [DATA_W-1:0] ktime;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
   } kvi_key_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              q_load;
      logic              wr_en;
      logic              rd_en;
      logic [KEY_AW-1:0] rd_addr;
      logic              ld_k;
      logic              chk;
      logic              div_step;
      logic              mul;
      logic              add;
      logic [1:0]        axis;
      logic              out_load;
      logic              out_blend;
      logic [KEY_AW-1:0] k;
   } kvi_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic fit;
   } kvi_stat_type;

endpackage

// File: rtl/kvi_dp.sv
module kvi_dp (
   input  logic                                clock,
   input  logic [kvi_pkg::KEY_AW-1:0]          req_key_index,
   input  logic [kvi_pkg::DATA_W-1:0]          req_key_time,
   input  logic signed [kvi_pkg::DATA_W-1:0]   req_key_x,
   input  logic signed [kvi_pkg::DATA_W-1:0]   req_key_y,
   input  logic signed [kvi_pkg::DATA_W-1:0]   req_key_z,
   input  logic [kvi_pkg::DATA_W-1:0]          req_query_time,
   input  kvi_pkg::kvi_cmd_type                cmd,
   output kvi_pkg::kvi_stat_type               stat,
   output logic signed [kvi_pkg::DATA_W-1:0]   rsp_out_x,
   output logic signed [kvi_pkg::DATA_W-1:0]   rsp_out_y,
   output logic signed [kvi_pkg::DATA_W-1:0]   rsp_out_z,
   output logic [kvi_pkg::KEY_AW-1:0]          rsp_key_used,
   output logic                                rsp_blended
);
   import kvi_pkg::*;

   kvi_key_type               key_mem_ff [MAX_KEYS];
   kvi_key_type               rd_q_ff;
   logic [DATA_W-1:0]         qt_ff;
   kvi_key_type               k0_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [DATA_W-1:0]         dt_ff, dt_in;
   logic [DATA_W-1:0]         rem_ff, rem_in;
   logic [FACT_W-1:0]         quot_ff, quot_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [DATA_W-1:0]         bx_ff, by_ff, bz_ff, blend_in;
   logic [DATA_W-1:0]         ox_ff, oy_ff, oz_ff;
   logic [KEY_AW-1:0]         used_ff;
   logic                      blended_ff;
   logic                      at_end;
   logic [DATA_W:0]           shifted;
   logic signed [DIFF_W-1:0]  mul_a;
   logic signed [FACT_W:0]    mul_b;
   logic [DATA_W-1:0]         base;

   // Key table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_mem_ff[req_key_index] <= {req_key_time, req_key_x, req_key_y, req_key_z};
      end
      if (cmd.rd_en) begin
         rd_q_ff <= key_mem_ff[cmd.rd_addr];
      end
   end

   // Scan compare and blend window test against the key read back.
   assign stat.hit = qt_ff < rd_q_ff.ktime;
   assign stat.fit = (k0_ff.ktime < rd_q_ff.ktime) && (k0_ff.ktime <= qt_ff) &&
                     (qt_ff <= rd_q_ff.ktime);
   assign at_end   = qt_ff == rd_q_ff.ktime;

   // Differences and divider setup; the top factor bit is set only at the end key.
   always_comb begin
      dx_in   = DIFF_W'(signed'(rd_q_ff.x)) - DIFF_W'(signed'(k0_ff.x));
      dy_in   = DIFF_W'(signed'(rd_q_ff.y)) - DIFF_W'(signed'(k0_ff.y));
      dz_in   = DIFF_W'(signed'(rd_q_ff.z)) - DIFF_W'(signed'(k0_ff.z));
      dt_in   = rd_q_ff.ktime - k0_ff.ktime;
      shifted = {rem_ff, 1'b0};
      if (cmd.chk) begin
         rem_in  = at_end ? '0 : (qt_ff - k0_ff.ktime);
         quot_in = {{(FACT_W-1){1'b0}}, at_end};
      end else if (shifted >= {1'b0, dt_ff}) begin
         rem_in  = DATA_W'(shifted - {1'b0, dt_ff});
         quot_in = {quot_ff[FACT_W-2:0], 1'b1};
      end else begin
         rem_in  = shifted[DATA_W-1:0];
         quot_in = {quot_ff[FACT_W-2:0], 1'b0};
      end
   end

   // Shared multiplier: one component per pass, product registered before the add.
   always_comb begin
      unique case (cmd.axis)
         AXIS_X: begin
            mul_a = dx_ff;
            base  = k0_ff.x;
         end
         AXIS_Y: begin
            mul_a = dy_ff;
            base  = k0_ff.y;
         end
         default: begin
            mul_a = dz_ff;
            base  = k0_ff.z;
         end
      endcase
      mul_b    = signed'({1'b0, quot_ff});
      prod_in  = mul_a * mul_b;
      // The arithmetic shift by the fraction width floors the scaled step.
      blend_in = base + prod_ff[FRAC_W+DATA_W-1:FRAC_W];
   end

   // Working registers, loaded under the controller's commands.
   always_ff @(posedge clock) begin
      if (cmd.q_load) begin
         qt_ff <= req_query_time;
      end
      if (cmd.ld_k) begin
         k0_ff <= rd_q_ff;
      end
      if (cmd.chk) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         dt_ff <= dt_in;
      end
      if (cmd.chk || cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.add) begin
         unique case (cmd.axis)
            AXIS_X:  bx_ff <= blend_in;
            AXIS_Y:  by_ff <= blend_in;
            default: bz_ff <= blend_in;
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ox_ff      <= cmd.out_blend ? bx_ff : k0_ff.x;
         oy_ff      <= cmd.out_blend ? by_ff : k0_ff.y;
         oz_ff      <= cmd.out_blend ? bz_ff : k0_ff.z;
         used_ff    <= cmd.k;
         blended_ff <= cmd.out_blend;
      end
   end

   assign rsp_out_x    = signed'(ox_ff);
   assign rsp_out_y    = signed'(oy_ff);
   assign rsp_out_z    = signed'(oz_ff);
   assign rsp_key_used = used_ff;
   assign rsp_blended  = blended_ff;

endmodule

// File: rtl/kvi_ctrl.sv
`include "keyframe_vector_interpolator_unit_assert.svh"

module kvi_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_mode,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       csr_wr_en,
   input  logic [kvi_pkg::CNT_W-1:0]  csr_wr_data,
   input  kvi_pkg::kvi_stat_type      stat,
   output kvi_pkg::kvi_cmd_type       cmd
);
   import kvi_pkg::*;

   kvi_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      key_count_ff;
   logic [CNT_W-1:0]      n_ff, n_in, n_sel;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [KEY_AW-1:0]     k_ff, k_in;
   logic [1:0]            axis_ff, axis_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  blend_ff, blend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Effective key count: zero acts as one, anything above the table acts as full.
   always_comb begin
      if (key_count_ff == '0) begin
         n_sel = CNT_W'(1);
      end else if (key_count_ff > CNT_W'(MAX_KEYS)) begin
         n_sel = CNT_W'(MAX_KEYS);
      end else begin
         n_sel = key_count_ff;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      k_in        = k_ff;
      axis_in     = axis_ff;
      div_cnt_in  = div_cnt_ff;
      blend_in    = blend_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.rd_addr = scan_ff[KEY_AW-1:0];
      cmd.axis    = axis_ff;
      cmd.k       = k_ff;
      cmd.out_blend = blend_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_QUERY) begin
                  cmd.q_load = 1'b1;
                  n_in       = n_sel;
                  k_in       = '0;
                  scan_in    = CNT_W'(1);
                  pend_in    = 1'b0;
                  state_in   = (n_sel == CNT_W'(1)) ? ST_RD_K : ST_SCAN;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         // One key time read per cycle; the compare sees the key issued in the previous cycle.
         ST_SCAN: begin
            if (pend_ff && stat.hit) begin
               k_in     = KEY_AW'(scan_ff - CNT_W'(2));
               state_in = ST_RD_K;
            end else if (scan_ff == n_ff) begin
               k_in     = '0;
               state_in = ST_RD_K;
            end else begin
               cmd.rd_en = 1'b1;
               scan_in   = scan_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end
         end
         ST_RD_K: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = k_ff;
            state_in    = ST_LD_K;
         end
         ST_LD_K: begin
            cmd.ld_k = 1'b1;
            if (n_ff == CNT_W'(1)) begin
               blend_in = 1'b0;
               state_in = ST_FIN;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = k_ff + KEY_AW'(1);
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.chk    = 1'b1;
            blend_in   = stat.fit;
            div_cnt_in = '0;
            state_in   = stat.fit ? ST_DIV : ST_FIN;
         end
         // One quotient bit per cycle.
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == '1) begin
               axis_in  = AXIS_X;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            if (axis_ff == AXIS_Z) begin
               state_in = ST_FIN;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Result beat flag.
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= CNT_W'(1);
         n_ff         <= CNT_W'(1);
         scan_ff      <= CNT_W'(1);
         pend_ff      <= 1'b0;
         k_ff         <= '0;
         axis_ff      <= AXIS_X;
         div_cnt_ff   <= '0;
         blend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         k_ff         <= k_in;
         axis_ff      <= axis_in;
         div_cnt_ff   <= div_cnt_in;
         blend_ff     <= blend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            key_count_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks on the sequencing.
   `KVI_ASSERT_SAME(a_load_slot_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `KVI_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_mode == MODE_QUERY, !req_ready, "query not held")
   `KVI_ASSERT_SAME(a_read_in_range, clock, reset, cmd.rd_en && state_ff != ST_IDLE, {1'b0, cmd.rd_addr} < n_ff, "read past key count")
   `KVI_ASSERT_SAME(a_mul_only_blend, clock, reset, cmd.mul, blend_ff, "multiply without blend")

endmodule

// File: rtl/keyframe_vector_interpolator_unit.sv
// Keyframe linear interpolator. Write beats (mode 0) store one key (time and xyz) in a
// 64-entry table and leave the unit idle; they give no result. A query beat (mode 1)
// scans the key times one per cycle through the table's single read port, then fetches
// key k and k+1, forms the Q1.16 factor with a one-bit-per-cycle divider and blends the
// three components through one shared multiplier. If the query time does not lie within
// keys k and k+1, key k is returned unblended, as is key 0 of a single-key track. One
// query is in flight at a time; a finished result sits in an output register, so the
// next beat is accepted while it waits. The key table powers up undefined: query only
// keys that have been written.
module keyframe_vector_interpolator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [kvi_pkg::KEY_AW-1:0]         req_key_index,
   input  logic [kvi_pkg::DATA_W-1:0]         req_key_time,
   input  logic signed [kvi_pkg::DATA_W-1:0]  req_key_x,
   input  logic signed [kvi_pkg::DATA_W-1:0]  req_key_y,
   input  logic signed [kvi_pkg::DATA_W-1:0]  req_key_z,
   input  logic [kvi_pkg::DATA_W-1:0]         req_query_time,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [kvi_pkg::DATA_W-1:0]  rsp_out_x,
   output logic signed [kvi_pkg::DATA_W-1:0]  rsp_out_y,
   output logic signed [kvi_pkg::DATA_W-1:0]  rsp_out_z,
   output logic [kvi_pkg::KEY_AW-1:0]         rsp_key_used,
   output logic                               rsp_blended,
   input  logic                               csr_wr_en,
   input  logic [kvi_pkg::CNT_W-1:0]          csr_wr_data
);
   import kvi_pkg::*;

   kvi_cmd_type  cmd;
   kvi_stat_type stat;

   // Sequencer.
   kvi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .cmd         (cmd)
   );

   // Key table, divider, blend and result register.
   kvi_dp u_dp (
      .clock          (clock),
      .req_key_index  (req_key_index),
      .req_key_time   (req_key_time),
      .req_key_x      (req_key_x),
      .req_key_y      (req_key_y),
      .req_key_z      (req_key_z),
      .req_query_time (req_query_time),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_key_used   (rsp_key_used),
      .rsp_blended    (rsp_blended)
   );

endmodule
